### hw/rtl/lolab_pkg.sv
// lolab_pkg: shared types and constants of the lattice orbit class labeler
// no dependencies; imported by lolab_front, lolab_back, the top level and the testbench
`default_nettype none

package lolab_pkg;

  localparam int LABEL_BITS  = 8;
  localparam int STATUS_BITS = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_EXISTING = 2'd0,
    ST_NEW      = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } lolab_status_t;

  typedef struct packed {
    logic restart;
    logic out_of_range;
  } lolab_flags_t;

  localparam int FLAGS_BITS = $bits(lolab_flags_t);

endpackage

`default_nettype wire

### hw/rtl/lolab_ram.sv
// lolab_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module lolab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/lolab_fifo.sv
// lolab_fifo: two-entry queue between the front classifier and the back search
// no dependencies
`default_nettype none

module lolab_fifo #(
  parameter int WIDTH = 34
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic      [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push & not_full;
  assign do_pop    = pop & not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue occupancy out of range");

endmodule

`default_nettype wire

### hw/rtl/lolab_front.sv
// lolab_front: forms the fourth barycentric coordinate, range check and 4-way sort
// depends on lolab_pkg
`default_nettype none

module lolab_front #(
  parameter int COORD_BITS = 8
) (
  input  wire logic [COORD_BITS-1:0]   coord_a,
  input  wire logic [COORD_BITS-1:0]   coord_b,
  input  wire logic [COORD_BITS-1:0]   coord_c,
  input  wire logic                    restart,
  input  wire logic [COORD_BITS:0]     side_length,
  output lolab_pkg::lolab_flags_t      flags,
  output logic      [4*COORD_BITS-1:0] tuple
);

  import lolab_pkg::*;

  localparam int CB = COORD_BITS;
  localparam logic [CB:0] SIDE_MAX = (CB+1)'(1) << CB;

  logic [CB:0]   side_cl;
  logic [CB+1:0] sum;
  logic [CB+1:0] d_wide;
  logic          oor;
  logic [CB-1:0] v   [4];
  logic [CB-1:0] s1  [4];
  logic [CB-1:0] s2  [4];

  always_comb begin
    side_cl = (side_length > SIDE_MAX) ? SIDE_MAX : side_length;
    sum     = {2'b00, coord_a} + {2'b00, coord_b} + {2'b00, coord_c};
    oor     = ({1'b0, side_cl} <= sum);
    d_wide  = {1'b0, side_cl} - (CB+2)'(1) - sum;

    v[0] = coord_a;
    v[1] = coord_b;
    v[2] = coord_c;
    v[3] = d_wide[CB-1:0];

    // first layer: pairs (0,1) and (2,3)
    s1[0] = (v[0] > v[1]) ? v[1] : v[0];
    s1[1] = (v[0] > v[1]) ? v[0] : v[1];
    s1[2] = (v[2] > v[3]) ? v[3] : v[2];
    s1[3] = (v[2] > v[3]) ? v[2] : v[3];
    // second layer: minima and maxima
    s2[0] = (s1[0] > s1[2]) ? s1[2] : s1[0];
    s2[2] = (s1[0] > s1[2]) ? s1[0] : s1[2];
    s2[1] = (s1[1] > s1[3]) ? s1[3] : s1[1];
    s2[3] = (s1[1] > s1[3]) ? s1[1] : s1[3];

    flags.restart      = restart;
    flags.out_of_range = oor;
    if (oor) begin
      tuple = '0;
    end else begin
      tuple = {s2[3],
               (s2[1] > s2[2]) ? s2[1] : s2[2],
               (s2[1] > s2[2]) ? s2[2] : s2[1],
               s2[0]};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lolab_back.sv
// lolab_back: class table search, append and result register
// depends on lolab_pkg and lolab_ram
`default_nettype none

module lolab_back #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_BITS  = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_valid,
  output logic                                    q_pop,
  input  wire lolab_pkg::lolab_flags_t            q_flags,
  input  wire logic [4*COORD_BITS-1:0]            q_tuple,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [lolab_pkg::LABEL_BITS-1:0]   out_class_label,
  output logic      [lolab_pkg::STATUS_BITS-1:0]  out_status,
  output logic      [4*COORD_BITS-1:0]            out_tuple
);

  import lolab_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = 4 * COORD_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MISS = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] eff_cnt;
  logic [TW-1:0] tuple_r, tuple_nxt;
  logic [AW-1:0] label_idx_r, label_idx_nxt;
  lolab_status_t res_status_r, res_status_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [LABEL_BITS-1:0] out_label_r;
  lolab_status_t out_status_r;
  logic [TW-1:0] out_tuple_r;
  logic          out_load;
  logic [AW+LABEL_BITS-1:0] label_wide;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [TW-1:0] ram_rdata;

  lolab_ram #(
    .WIDTH (TW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tuple_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign label_wide = {{LABEL_BITS{1'b0}}, label_idx_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    tuple_nxt      = tuple_r;
    label_idx_nxt  = label_idx_r;
    res_status_nxt = res_status_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_raddr      = '0;
    out_load       = 1'b0;
    idx_inc        = idx_r + CW'(1);
    eff_cnt        = q_flags.restart ? '0 : count_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          tuple_nxt = q_tuple;
          count_nxt = eff_cnt;
          idx_nxt   = '0;
          if (q_flags.out_of_range) begin
            res_status_nxt = ST_RANGE;
            label_idx_nxt  = '0;
            state_nxt      = S_DONE;
          end else if (eff_cnt == '0) begin
            state_nxt = S_MISS;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = idx_inc[AW-1:0];
        if (ram_rdata == tuple_r) begin
          res_status_nxt = ST_EXISTING;
          label_idx_nxt  = idx_r[AW-1:0];
          state_nxt      = S_DONE;
        end else if (idx_inc == count_r) begin
          state_nxt = S_MISS;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_MISS: begin
        if (count_r == DEPTH_C) begin
          res_status_nxt = ST_FULL;
          label_idx_nxt  = '0;
        end else begin
          ram_we         = 1'b1;
          res_status_nxt = ST_NEW;
          label_idx_nxt  = count_r[AW-1:0];
          count_nxt      = count_r + CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    tuple_r      <= tuple_nxt;
    label_idx_r  <= label_idx_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_label_r  <= label_wide[LABEL_BITS-1:0];
      out_status_r <= res_status_r;
      out_tuple_r  <= tuple_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_class_label = out_label_r;
  assign out_status      = out_status_r;
  assign out_tuple       = out_tuple_r;

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= DEPTH_C)
    else $error("class count beyond table depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (count_r == $past(count_r) + CW'(1)) && (res_status_r == ST_NEW))
    else $error("table append without count advance");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r < count_r))
    else $error("search beyond filled entries");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE) && q_valid)
    else $error("queue read outside idle");

endmodule

`default_nettype wire

### hw/rtl/lattice_orbit_class_labeler_unit.sv
// lattice_orbit_class_labeler_unit: top level, side length register and block wiring
// depends on lolab_pkg, lolab_front, lolab_fifo, lolab_back (and lolab_ram below it)
//
// usage:
//   input channel (in_valid/in_ready): three lattice coordinates and a restart flag.
//   the front sorts the barycentric tuple in the accepting cycle and places it in a
//   two-entry queue, so up to two points plus one in search can be taken ahead.
//   the back pops a point, walks the class table one entry per cycle through the
//   ram read port, reading at most the class count of entries, then appends on a
//   miss; an out-of-range point skips the search and goes straight to its result.
//   result channel (out_valid/out_ready): label, status and the sorted tuple,
//   held in an output register; while the receiver stalls the back finishes the
//   next point and the queue keeps taking input until it fills.
//   cfg_wr_en writes side_length into its register; write only while the block is idle.
//   reset: synchronous, active low; empties the class table (count to zero),
//   sets side_length to 4, drops any queued points. no clearing pass is needed.
`default_nettype none

module lattice_orbit_class_labeler_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_BITS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [COORD_BITS:0]               cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [COORD_BITS-1:0]             in_coord_a,
  input  wire logic [COORD_BITS-1:0]             in_coord_b,
  input  wire logic [COORD_BITS-1:0]             in_coord_c,
  input  wire logic                              in_restart,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [lolab_pkg::LABEL_BITS-1:0]  out_class_label,
  output logic      [lolab_pkg::STATUS_BITS-1:0] out_status,
  output logic      [COORD_BITS-1:0]             out_sorted_0,
  output logic      [COORD_BITS-1:0]             out_sorted_1,
  output logic      [COORD_BITS-1:0]             out_sorted_2,
  output logic      [COORD_BITS-1:0]             out_sorted_3
);

  import lolab_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int TW = 4 * CB;
  localparam int QW = FLAGS_BITS + TW;

  logic [CB:0]   side_length_r, side_length_nxt;
  lolab_flags_t  f_flags;
  logic [TW-1:0] f_tuple;
  logic          q_not_full;
  logic          q_not_empty;
  logic          q_pop;
  logic [QW-1:0] q_data;
  lolab_flags_t  q_flags;
  logic [TW-1:0] q_tuple;
  logic [TW-1:0] res_tuple;

  assign side_length_nxt = cfg_wr_en ? cfg_wr_data : side_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_length_r <= (CB+1)'(4);
    end else begin
      side_length_r <= side_length_nxt;
    end
  end

  lolab_front #(
    .COORD_BITS (CB)
  ) u_front (
    .coord_a     (in_coord_a),
    .coord_b     (in_coord_b),
    .coord_c     (in_coord_c),
    .restart     (in_restart),
    .side_length (side_length_r),
    .flags       (f_flags),
    .tuple       (f_tuple)
  );

  assign in_ready = q_not_full;

  lolab_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data ({f_flags, f_tuple}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  assign q_flags = q_data[QW-1:TW];
  assign q_tuple = q_data[TW-1:0];

  lolab_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (CB)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_not_empty),
    .q_pop           (q_pop),
    .q_flags         (q_flags),
    .q_tuple         (q_tuple),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_class_label (out_class_label),
    .out_status      (out_status),
    .out_tuple       (res_tuple)
  );

  assign out_sorted_0 = res_tuple[CB-1:0];
  assign out_sorted_1 = res_tuple[2*CB-1:CB];
  assign out_sorted_2 = res_tuple[3*CB-1:2*CB];
  assign out_sorted_3 = res_tuple[4*CB-1:3*CB];

endmodule

`default_nettype wire

### sim/tb_lattice_orbit_class_labeler_unit.sv
// tb_lattice_orbit_class_labeler_unit: self-checking testbench of the orbit class labeler
// depends on lolab_pkg and lattice_orbit_class_labeler_unit; a directed table, then random
// phases over several side lengths; results match a row's want or a behavioural class table
`default_nettype none

module tb_lattice_orbit_class_labeler_unit;
  import lolab_pkg::*;

  localparam int DEPTH        = 256;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASES       = 8;
  localparam int FILL_PHASE   = 4;
  localparam int RANDOM_TOTAL = 1000;
  localparam int ROWS         = 22;

  typedef struct packed {
    logic [7:0]    label;
    lolab_status_t status;
    logic [7:0]    s0;
    logic [7:0]    s1;
    logic [7:0]    s2;
    logic [7:0]    s3;
  } orbit_result_t;

  typedef struct packed {
    logic [8:0]    side;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [7:0]    c;
    logic          restart;
    logic          typed;
    orbit_result_t want;
  } stim_row_t;

  localparam orbit_result_t PREDICTED = '0;
  localparam orbit_result_t NO_FIT    = '{8'd0, ST_RANGE, 8'd0, 8'd0, 8'd0, 8'd0};

  localparam stim_row_t PLAN [ROWS] = '{
    '{9'd4,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, '{8'd0, ST_NEW,      8'd0, 8'd0, 8'd0, 8'd3}},
    '{9'd4,   8'd3,   8'd0,   8'd0,   1'b0, 1'b1, '{8'd0, ST_EXISTING, 8'd0, 8'd0, 8'd0, 8'd3}},
    '{9'd4,   8'd0,   8'd1,   8'd2,   1'b0, 1'b1, '{8'd1, ST_NEW,      8'd0, 8'd0, 8'd1, 8'd2}},
    '{9'd4,   8'd1,   8'd1,   8'd1,   1'b0, 1'b1, '{8'd2, ST_NEW,      8'd0, 8'd1, 8'd1, 8'd1}},
    '{9'd4,   8'd2,   8'd1,   8'd0,   1'b0, 1'b1, '{8'd1, ST_EXISTING, 8'd0, 8'd0, 8'd1, 8'd2}},
    '{9'd4,   8'd255, 8'd255, 8'd255, 1'b0, 1'b1, NO_FIT},
    '{9'd4,   8'd4,   8'd0,   8'd0,   1'b0, 1'b1, NO_FIT},
    '{9'd4,   8'd0,   8'd0,   8'd1,   1'b1, 1'b1, '{8'd0, ST_NEW,      8'd0, 8'd0, 8'd1, 8'd2}},
    '{9'd4,   8'd1,   8'd1,   8'd1,   1'b0, 1'b1, '{8'd1, ST_NEW,      8'd0, 8'd1, 8'd1, 8'd1}},
    '{9'd4,   8'd0,   8'd3,   8'd0,   1'b0, 1'b1, '{8'd2, ST_NEW,      8'd0, 8'd0, 8'd0, 8'd3}},
    '{9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, NO_FIT},
    '{9'd1,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, PREDICTED},
    '{9'd1,   8'd0,   8'd0,   8'd1,   1'b0, 1'b1, NO_FIT},
    '{9'd256, 8'd255, 8'd0,   8'd0,   1'b0, 1'b0, PREDICTED},
    '{9'd256, 8'd85,  8'd85,  8'd85,  1'b1, 1'b1, '{8'd0, ST_NEW,      8'd0, 8'd85, 8'd85, 8'd85}},
    '{9'd256, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, PREDICTED},
    '{9'd256, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, NO_FIT},
    '{9'd256, 8'd170, 8'd85,  8'd0,   1'b0, 1'b0, PREDICTED},
    '{9'd511, 8'd0,   8'd0,   8'd255, 1'b0, 1'b0, PREDICTED},
    '{9'd511, 8'd128, 8'd128, 8'd0,   1'b0, 1'b1, NO_FIT},
    '{9'd511, 8'd1,   8'd2,   8'd4,   1'b0, 1'b0, PREDICTED},
    '{9'd257, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, PREDICTED}
  };

  int phase_side [PHASES] = '{4, 9, 0, 1, 256, 511, 20, 137};
  int phase_len  [PHASES] = '{150, 150, 30, 40, 320, 60, 150, 100};

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic [8:0] cfg_wr_data = '0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_coord_a  = '0;
  logic [7:0] in_coord_b  = '0;
  logic [7:0] in_coord_c  = '0;
  logic       in_restart  = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_class_label;
  logic [1:0] out_status;
  logic [7:0] out_sorted_0;
  logic [7:0] out_sorted_1;
  logic [7:0] out_sorted_2;
  logic [7:0] out_sorted_3;

  lattice_orbit_class_labeler_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_coord_a      (in_coord_a),
    .in_coord_b      (in_coord_b),
    .in_coord_c      (in_coord_c),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_class_label (out_class_label),
    .out_status      (out_status),
    .out_sorted_0    (out_sorted_0),
    .out_sorted_1    (out_sorted_1),
    .out_sorted_2    (out_sorted_2),
    .out_sorted_3    (out_sorted_3)
  );

  // behavioural copy of the class table
  logic [31:0]   known_tuples [DEPTH];
  int unsigned   class_total = 0;
  logic [8:0]    side_reg    = 9'd4;
  orbit_result_t awaited_orbits [$];
  int            idle_mode   = 0;
  int            mismatches  = 0;
  int            cycles      = 0;

  function automatic orbit_result_t classify_point(input logic [7:0] a, b, c, input logic restart);
    orbit_result_t r;
    int unsigned   eff;
    int unsigned   sum;
    logic [7:0]    v [4];
    logic [7:0]    t;
    int            hit;
    r = '0;
    hit = -1;
    if (restart) class_total = 0;
    eff = (side_reg > 9'd256) ? 256 : int'(side_reg);
    sum = a + b + c;
    if (eff == 0 || sum > eff - 1) begin
      r.status = ST_RANGE;
      return r;
    end
    v[0] = a;
    v[1] = b;
    v[2] = c;
    v[3] = 8'(eff - 1 - sum);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3 - i; j++) begin
        if (v[j] > v[j+1]) begin
          t = v[j];
          v[j] = v[j+1];
          v[j+1] = t;
        end
      end
    end
    r.s0 = v[0];
    r.s1 = v[1];
    r.s2 = v[2];
    r.s3 = v[3];
    for (int k = 0; k < int'(class_total); k++) begin
      if (known_tuples[k] == {v[0], v[1], v[2], v[3]}) begin
        hit = k;
        break;
      end
    end
    if (hit >= 0) begin
      r.label  = 8'(hit);
      r.status = ST_EXISTING;
    end else if (class_total >= DEPTH) begin
      r.status = ST_FULL;
    end else begin
      known_tuples[class_total] = {v[0], v[1], v[2], v[3]};
      r.label  = 8'(class_total);
      r.status = ST_NEW;
      class_total++;
    end
    return r;
  endfunction

  function automatic int sender_idle_pct();
    return (idle_mode == 0) ? 20 : (idle_mode == 1) ? 49 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    return (idle_mode == 0) ? 49 : (idle_mode == 1) ? 20 : 0;
  endfunction

  task automatic send_point(input logic [7:0] a, b, c, input logic restart,
                            input logic typed, input orbit_result_t want);
    orbit_result_t guess;
    int            pct;
    pct = sender_idle_pct();
    if ($urandom_range(99, 0) < pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < pct);
    end
    in_valid   <= 1'b1;
    in_coord_a <= a;
    in_coord_b <= b;
    in_coord_c <= c;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    guess = classify_point(a, b, c, restart);
    awaited_orbits.insert(awaited_orbits.size(), typed ? want : guess);
  endtask

  // side length only changes once every transfer has come back
  task automatic write_side(input logic [8:0] v);
    in_valid <= 1'b0;
    while (awaited_orbits.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    side_reg = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= receiver_idle_pct());
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    orbit_result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_orbits.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result: label %0d status %0d sorted %0d %0d %0d %0d",
                   out_class_label, out_status, out_sorted_0, out_sorted_1,
                   out_sorted_2, out_sorted_3);
      end else begin
        w = awaited_orbits.pop_front();
        if (out_class_label !== w.label || out_status !== w.status ||
            out_sorted_0 !== w.s0 || out_sorted_1 !== w.s1 ||
            out_sorted_2 !== w.s2 || out_sorted_3 !== w.s3) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: want %0d %0d (%0d %0d %0d %0d), got %0d %0d (%0d %0d %0d %0d)",
                     w.label, w.status, w.s0, w.s1, w.s2, w.s3,
                     out_class_label, out_status, out_sorted_0, out_sorted_1,
                     out_sorted_2, out_sorted_3);
        end
      end
    end
  end

  initial begin
    int          done;
    int          eff;
    int          m;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned t;
    logic        rs;
    done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      if (PLAN[r].side != side_reg) write_side(PLAN[r].side);
      send_point(PLAN[r].a, PLAN[r].b, PLAN[r].c, PLAN[r].restart, PLAN[r].typed, PLAN[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_side(9'(phase_side[p]));
      eff = (phase_side[p] > 256) ? 256 : phase_side[p];
      for (int i = 0; i < phase_len[p]; i++) begin
        idle_mode = (done * 3) / RANDOM_TOTAL;
        if (idle_mode > 2) idle_mode = 2;
        if (p == FILL_PHASE) rs = (i == 0);
        else rs = ($urandom_range(99, 0) < 3);
        if (eff == 0 || $urandom_range(99, 0) < 15) begin
          // noise over the whole coordinate range
          a = $urandom_range(255, 0);
          b = $urandom_range(255, 0);
          c = $urandom_range(255, 0);
        end else begin
          m = eff - 1;
          a = $urandom_range(m, 0);
          b = $urandom_range(m - a, 0);
          c = $urandom_range(m - a - b, 0);
          case ($urandom_range(2, 0))
            0: begin t = a; a = b; b = c; c = t; end
            1: begin t = a; a = c; c = b; b = t; end
            default: ;
          endcase
        end
        send_point(8'(a), 8'(b), 8'(c), rs, 1'b0, PREDICTED);
        done++;
      end
    end

    in_valid <= 1'b0;
    while (awaited_orbits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_orbits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
